// File: sv/encoder_period_speed_defines.svh
// ----------------------------------------------------------------------------
// encoder_period_speed assertion macros
// Shared concurrent assertion helpers, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef ENCODER_PERIOD_SPEED_DEFINES_SVH
`define ENCODER_PERIOD_SPEED_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define EPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EPS_ASSERT_IMPL(lbl, ante, cons, msg)
`define EPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/eps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_pkg
// Widths, register codes, reset values and shared types of the encoder
// period speed block.
// ----------------------------------------------------------------------------
package eps_pkg;

    localparam int TS_W      = 32;              // timestamp, position, period
    localparam int NUM_W     = 24;              // speed numerator
    localparam int FRAC_BITS = 8;               // fraction bits of the speed
    localparam int DEB_W     = 16;
    localparam int TMO_W     = 24;
    localparam int CFG_W     = 24;              // widest register
    localparam int DIV_W     = NUM_W + FRAC_BITS;
    localparam int DEN_W     = TS_W;
    localparam int CNT_W     = $clog2(DIV_W + 1);

    localparam logic [DEB_W-1:0] DEBOUNCE_RST  = DEB_W'(500);
    localparam logic [TMO_W-1:0] TIMEOUT_RST   = TMO_W'(100000);
    localparam logic [NUM_W-1:0] NUMERATOR_RST = NUM_W'(10000000);

    localparam logic [TS_W-1:0] SPEED_MAX = {1'b0, {(TS_W-1){1'b1}}};
    localparam logic [TS_W-1:0] SPEED_MIN = {1'b1, {(TS_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_DEBOUNCE  = 2'd1,
        CFG_TIMEOUT   = 2'd2,
        CFG_NUMERATOR = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: sv/eps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_if
// Valid/ready channels for the encoder input beats and the result beats.
// ----------------------------------------------------------------------------
interface eps_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] now_us;
    logic        b_level;

    modport source (output valid, output action, output now_us, output b_level,
                    input ready);
    modport sink   (input valid, input action, input now_us, input b_level,
                    output ready);
endinterface

interface eps_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] speed_q8;
    logic               edge_taken;

    modport source (output valid, output position, output speed_q8,
                    output edge_taken, input ready);
    modport sink   (input valid, input position, input speed_q8,
                    input edge_taken, output ready);
endinterface

// File: sv/eps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_div
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "encoder_period_speed_defines.svh"

module eps_div
    import eps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DEN_W-1:0] rem_reg,   rem_next;
    logic [DIV_W-1:0] quo_reg,   quo_next;
    logic [DEN_W-1:0] den_reg,   den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // The shifted remainder is one bit wider than the divisor; a clear top bit
    // of the difference means the divisor fits.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `EPS_ASSERT_IMPL(a_no_restart, req.start, !busy_reg, "divider started while busy")
    `EPS_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg && !busy_reg, "done held too long")
    `EPS_ASSERT_IMPL(a_rem_bound, busy_reg && !req.start && cnt_reg != CNT_W'(DIV_W),
                     rem_reg < den_reg, "partial remainder not below divisor")

endmodule

// File: sv/encoder_period_speed.sv
// ----------------------------------------------------------------------------
// encoder_period_speed
// Each input beat passes IDLE, EVAL, DIV (skipped when the speed is zero) and DONE.
// A new beat is taken only in IDLE, once the result of the last one is loaded.
// Reset clears position, period and last edge time, and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "encoder_period_speed_defines.svh"

module encoder_period_speed
    import eps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_idx,
    input  logic [CFG_W-1:0] cfg_data,
    eps_in_if.sink           item,
    eps_out_if.source        result
);

    // Configuration registers.
    logic             enable_reg;
    logic [DEB_W-1:0] debounce_reg;
    logic [TMO_W-1:0] timeout_reg;
    logic [NUM_W-1:0] numerator_reg;

    // Encoder state.
    logic [TS_W-1:0]  last_edge_reg;
    logic [TS_W-1:0]  period_reg;
    logic [TS_W-1:0]  step_count_reg;

    // Per-item working registers.
    state_t           state_reg, state_next;
    logic [TS_W-1:0]  now_reg;
    logic             taken_reg;
    logic             neg_reg;
    logic [TS_W-1:0]  speed_reg;

    // Result register.
    logic             out_valid_reg;
    logic [TS_W-1:0]  out_pos_reg;
    logic [TS_W-1:0]  out_speed_reg;
    logic             out_taken_reg;

    logic             in_fire;
    logic             out_load;
    logic [TS_W-1:0]  gap;
    logic             edge_ok;
    logic [TS_W-1:0]  elapsed;
    logic             speed_zero;
    logic [TS_W-1:0]  period_mag;
    logic [63:0]      quo_ext;
    logic [TS_W-1:0]  speed_sat;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    eps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            debounce_reg  <= DEBOUNCE_RST;
            timeout_reg   <= TIMEOUT_RST;
            numerator_reg <= NUMERATOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_ENABLE:    enable_reg    <= cfg_data[0];
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data[DEB_W-1:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[TMO_W-1:0];
                CFG_NUMERATOR: numerator_reg <= cfg_data[NUM_W-1:0];
                default:       ;
            endcase
        end
    end

    assign in_fire = item.valid && item.ready;

    // A negative signed gap is below any debounce time.
    assign gap     = item.now_us - last_edge_reg;
    assign edge_ok = item.action && enable_reg && !gap[TS_W-1]
                     && (gap >= TS_W'(debounce_reg));

    assign elapsed    = now_reg - last_edge_reg;
    assign speed_zero = !enable_reg || (elapsed > TS_W'(timeout_reg))
                        || (period_reg == '0);
    assign period_mag = period_reg[TS_W-1] ? (TS_W'(0) - period_reg) : period_reg;

    assign quo_ext = 64'(div_rsp.quotient);
    always_comb
    begin
        if (!neg_reg)
        begin
            speed_sat = (quo_ext > 64'(SPEED_MAX)) ? SPEED_MAX : TS_W'(quo_ext);
        end
        else
        begin
            speed_sat = (quo_ext > 64'(SPEED_MIN)) ? SPEED_MIN
                                                    : (TS_W'(0) - TS_W'(quo_ext));
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_EVAL;
            ST_EVAL: state_next = speed_zero ? ST_DONE : ST_DIV;
            ST_DIV:  if (div_rsp.done) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        item.ready       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(numerator_reg) << FRAC_BITS;
        div_req.divisor  = period_mag;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_IDLE: item.ready    = 1'b1;
            ST_EVAL: div_req.start = !speed_zero;
            ST_DIV:  ;
            ST_DONE: out_load      = !out_valid_reg || result.ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_edge_reg  <= '0;
            period_reg     <= '0;
            step_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && edge_ok)
            begin
                last_edge_reg <= item.now_us;
                if (item.b_level)
                begin
                    step_count_reg <= step_count_reg - TS_W'(1);
                    period_reg     <= gap;
                end
                else
                begin
                    step_count_reg <= step_count_reg + TS_W'(1);
                    period_reg     <= TS_W'(0) - gap;
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg   <= item.now_us;
            taken_reg <= edge_ok;
        end
        if (state_reg == ST_EVAL)
        begin
            neg_reg   <= period_reg[TS_W-1];
            speed_reg <= '0;
        end
        if (state_reg == ST_DIV && div_rsp.done)
            speed_reg <= speed_sat;
        if (out_load)
        begin
            out_pos_reg   <= step_count_reg;
            out_speed_reg <= speed_reg;
            out_taken_reg <= taken_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.position   = out_pos_reg;
    assign result.speed_q8   = out_speed_reg;
    assign result.edge_taken = out_taken_reg;

    `EPS_ASSERT_NEXT(a_div_to_done, state_reg == ST_DIV && div_rsp.done,
                     state_reg == ST_DONE, "divider result not taken")
    `EPS_ASSERT_NEXT(a_state_hold, !in_fire,
                     $stable(step_count_reg) && $stable(last_edge_reg),
                     "encoder state changed without an input beat")
    `EPS_ASSERT_IMPL(a_speed_enable, out_valid_reg && out_speed_reg != '0,
                     enable_reg, "nonzero speed while disabled")

endmodule

// File: tb/sv/tb_encoder_period_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_period_speed
// Drives timestamped encoder beats and register settings into the period
// speed block and checks every result beat against a cycle-free prediction
// of position, signed Q8 speed and edge acceptance.
// ----------------------------------------------------------------------------
module tb_encoder_period_speed;
    import eps_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        logic signed [31:0] position;
        logic signed [31:0] speed_q8;
        logic               edge_taken;
    } speed_reading_t;

    class speed_scoreboard;
        bit [0:0]       enable;
        bit [15:0]      debounce;
        bit [23:0]      timeout;
        bit [23:0]      numerator;
        bit [31:0]      last_edge;
        bit [31:0]      period;
        bit [31:0]      steps;
        speed_reading_t expected_readings[$];
        int             errors;

        function new();
            enable    = 1'b0;
            debounce  = DEBOUNCE_RST;
            timeout   = TIMEOUT_RST;
            numerator = NUMERATOR_RST;
            last_edge = '0;
            period    = '0;
            steps     = '0;
            errors    = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, bit [CFG_W-1:0] value);
            case (idx)
                CFG_ENABLE:    enable    = value[0];
                CFG_DEBOUNCE:  debounce  = value[15:0];
                CFG_TIMEOUT:   timeout   = value[23:0];
                CFG_NUMERATOR: numerator = value[23:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] predict_speed(bit [31:0] now);
            bit [31:0]            since_edge;
            longint signed        per;
            longint unsigned      mag;
            longint unsigned      dividend;
            longint unsigned      quot;
            since_edge = now - last_edge;
            if (!enable || since_edge > {8'd0, timeout})
                return '0;
            per = longint'($signed(period));
            if (per == 0)
                return '0;
            mag = (per < 0) ? longint'(-per) : longint'(per);
            dividend = numerator;
            dividend = dividend << FRAC_BITS;
            quot = dividend / mag;
            if (per > 0)
                return (quot > 64'h7FFF_FFFF) ? SPEED_MAX : quot[31:0];
            if (quot > 64'h8000_0000)
                quot = 64'h8000_0000;
            return 32'd0 - quot[31:0];
        endfunction

        // An accepted edge updates the state before the speed of the same beat.
        function void note_sample(bit action, bit [31:0] now, bit b_level);
            bit [31:0]      gap;
            speed_reading_t exp_r;
            exp_r.edge_taken = 1'b0;
            if (action && enable)
            begin
                gap = now - last_edge;
                if ($signed(gap) >= $signed({16'd0, debounce}))
                begin
                    last_edge = now;
                    if (b_level)
                    begin
                        steps  = steps - 1;
                        period = gap;
                    end
                    else
                    begin
                        steps  = steps + 1;
                        period = 32'd0 - gap;
                    end
                    exp_r.edge_taken = 1'b1;
                end
            end
            exp_r.position = steps;
            exp_r.speed_q8 = predict_speed(now);
            expected_readings.insert(expected_readings.size(), exp_r);
        endfunction

        function void check_reading(logic signed [31:0] position,
                                    logic signed [31:0] speed_q8, logic edge_taken);
            speed_reading_t exp_r;
            if (expected_readings.size() == 0)
            begin
                $error("result beat with no expected reading: position %0d speed_q8 %0d",
                       position, speed_q8);
                errors++;
                return;
            end
            exp_r = expected_readings[0];
            expected_readings.delete(0);
            if (position !== exp_r.position)
            begin
                $error("position: expected %0d, got %0d", exp_r.position, position);
                errors++;
            end
            if (speed_q8 !== exp_r.speed_q8)
            begin
                $error("speed_q8: expected %0d, got %0d", exp_r.speed_q8, speed_q8);
                errors++;
            end
            if (edge_taken !== exp_r.edge_taken)
            begin
                $error("edge_taken: expected %0d, got %0d", exp_r.edge_taken, edge_taken);
                errors++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_idx_t         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    eps_in_if  item_ch();
    eps_out_if result_ch();

    speed_scoreboard tracker = new();

    bit          in_gaps;
    bit          out_stalls;
    logic [31:0] stamp;
    logic        dir_b;
    int          deb;
    int          tmo;
    int          spread;

    encoder_period_speed i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Sends one beat; valid stays high into the next beat unless a gap is drawn.
    task automatic send_sample(input logic action, input logic [31:0] now,
                               input logic b_level);
        if (in_gaps && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.action  <= action;
        item_ch.now_us  <= now;
        item_ch.b_level <= b_level;
        do
            @(posedge clk);
        while (!item_ch.ready);
        tracker.note_sample(action, now, b_level);
    endtask

    // Registers may only change while nothing is in flight.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic en, input logic [15:0] debounce,
                             input logic [23:0] timeout, input logic [23:0] numerator);
        logic [CFG_W-1:0] values[4];
        cfg_idx_t         idx;
        values[0] = CFG_W'(en);
        values[1] = CFG_W'(debounce);
        values[2] = timeout;
        values[3] = numerator;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_idx_t'(i);
            cfg_we   <= 1'b1;
            cfg_idx  <= idx;
            cfg_data <= values[i];
            @(posedge clk);
            tracker.write_reg(idx, values[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly clean edge trains in one direction, with bounces, queries,
    // timeouts, backward stamps and fully random beats mixed in.
    task automatic random_sample();
        int          r;
        logic        b;
        logic [31:0] t;
        r = $urandom_range(0, 99);
        b = 1'($urandom_range(0, 1));
        if (r < 55)
        begin
            if ($urandom_range(0, 15) == 0)
                dir_b = ~dir_b;
            stamp = stamp + deb + $urandom_range(0, spread);
            send_sample(1'b1, stamp, dir_b);
        end
        else if (r < 65)
        begin
            if (deb > 0)
                stamp = stamp + $urandom_range(0, deb - 1);
            send_sample(1'b1, stamp, b);
        end
        else if (r < 85)
        begin
            stamp = stamp + $urandom_range(0, spread);
            send_sample(1'b0, stamp, b);
        end
        else if (r < 90)
        begin
            stamp = stamp + tmo + $urandom_range(0, 1);
            send_sample(1'($urandom_range(0, 1)), stamp, b);
        end
        else if (r < 95)
        begin
            t = stamp - $urandom_range(1, 1 << 20);
            send_sample(1'b1, t, b);
        end
        else
        begin
            stamp = $urandom;
            send_sample(1'($urandom_range(0, 1)), stamp, b);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.check_reading(result_ch.position, result_ch.speed_q8,
                                  result_ch.edge_taken);
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (out_stalls && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int n_items;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_ENABLE;
        cfg_data        <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.action  <= 1'b0;
        item_ch.now_us  <= '0;
        item_ch.b_level <= 1'b0;
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
        dir_b      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults leave the block disabled.
        send_sample(1'b1, 32'd1000, 1'b0);
        send_sample(1'b0, 32'hFFFF_FFFF, 1'b1);

        settle();
        configure(1'b1, 16'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        send_sample(1'b1, 32'h0000_0000, 1'b1);   // zero period
        send_sample(1'b1, 32'h0000_0001, 1'b0);   // period -1 saturates low
        send_sample(1'b1, 32'h0000_0002, 1'b1);   // period +1 saturates high
        send_sample(1'b0, 32'h0100_0001, 1'b0);   // gap equal to timeout
        send_sample(1'b0, 32'h0100_0002, 1'b0);   // one past timeout
        send_sample(1'b1, 32'h0000_0001, 1'b0);   // backward stamp
        send_sample(1'b1, 32'h8000_0002, 1'b1);   // gap reads as negative
        send_sample(1'b1, 32'h7FFF_FFF0, 1'b1);
        send_sample(1'b1, 32'hFFFF_FF00, 1'b0);
        send_sample(1'b1, 32'h0000_0010, 1'b0);   // across the wrap

        settle();
        configure(1'b1, 16'hFFFF, 24'd0, 24'hFF_FFFF);
        send_sample(1'b1, 32'h0001_000E, 1'b1);   // one short of debounce
        send_sample(1'b1, 32'h0001_000F, 1'b1);
        send_sample(1'b0, 32'h0001_000F, 1'b0);
        send_sample(1'b0, 32'h0001_0010, 1'b1);   // zero timeout

        settle();
        configure(1'b1, 16'd1, 24'd1000, 24'h80_0000);
        send_sample(1'b1, 32'h0001_0010, 1'b1);   // quotient exactly 2^31
        send_sample(1'b1, 32'h0001_0011, 1'b0);
        send_sample(1'b1, 32'h0001_0011, 1'b0);   // bounce

        settle();
        configure(1'b1, 16'd500, 24'd100000, 24'd0);
        send_sample(1'b1, 32'h0001_02CD, 1'b1);   // zero numerator

        settle();
        configure(1'b0, 16'd500, 24'd100000, 24'd10000000);
        send_sample(1'b1, 32'h0001_06B5, 1'b0);

        stamp = 32'h0001_06B5;
        for (int p = 0; p < 6; p++)
        begin
            case ($urandom_range(0, 4))
                0: deb = 0;
                1: deb = $urandom_range(1, 20);
                2: deb = 500;
                3: deb = $urandom_range(21, 5000);
                default: deb = (p == 1) ? 65535 : $urandom_range(0, 65535);
            endcase
            spread = $urandom_range(1, 4 * deb + 200);
            case ($urandom_range(0, 3))
                0: tmo = 24'hFF_FFFF;
                1: tmo = 100000;
                2: tmo = deb + spread / 2;
                default: tmo = $urandom_range(0, 24'hFF_FFFF);
            endcase
            if (p == 5)
            begin
                in_gaps    = 1'b0;
                out_stalls = 1'b0;
            end
            settle();
            configure(p != 3, deb[15:0], tmo[23:0],
                      (p == 0) ? 24'd1 : (p == 2) ? 24'hFF_FFFF :
                      (p == 4) ? 24'd10000000 : 24'($urandom_range(1, 24'hFF_FFFF)));
            n_items = (p == 3) ? 100 : 370;
            for (int n = 0; n < n_items; n++)
                random_sample();
        end

        item_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
